[rtl/core/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/ftpa_pkg.sv]
// shared types and constants of the flow table accumulator
package ftpa_pkg;

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvMult  = 64'h00000100000001b3;
  localparam int unsigned LoadNum  = 7;
  localparam int unsigned LoadDen  = 10;
  localparam logic [7:0]  ProtoTcp = 8'd6;

  localparam logic [1:0] StIgnored = 2'd0;
  localparam logic [1:0] StNew     = 2'd1;
  localparam logic [1:0] StUpdated = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [1:0] LvlNone = 2'd0;
  localparam logic [1:0] LvlL3   = 2'd1;

  // valid flag, key, hash and record packed as one memory word
  typedef struct packed {
    logic        vld;
    logic [63:0] addr_a_hi;
    logic [63:0] addr_a_lo;
    logic [63:0] addr_b_hi;
    logic [63:0] addr_b_lo;
    logic [43:0] key_rest;
    logic [63:0] hash;
    logic [63:0] packets;
    logic [63:0] bytes;
    logic [63:0] first_ns;
    logic [63:0] last_ns;
    logic [8:0]  flags_dir;
  } slot_rec_t;

  typedef struct packed {
    logic [1:0]  header_level;
    logic [3:0]  ip_ver;
    logic [7:0]  protocol;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] port_src;
    logic [15:0] port_dst;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] wire_length;
    logic [63:0] timestamp_ns;
  } pkt_hdr_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot_index;
    logic        packet_reversed;
    logic [63:0] flow_packets;
    logic [63:0] flow_bytes;
    logic [63:0] flow_first_ns;
    logic [63:0] flow_last_ns;
    logic [7:0]  flow_tcp_flags;
    logic        first_dir_b;
  } flow_res_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture header, canonicalize
    logic hash_step;  // mix one byte
    logic probe_init; // start index from hash
    logic probe_next; // advance index
    logic wr_new;     // write new record
    logic wr_upd;     // write updated record
    logic res_zero;   // result with zero fields
  } ftpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clearing;
    logic no_l3;
    logic hash_done;
    logic slot_valid;
    logic key_match;
    logic wrapped;
    logic load_full;
  } ftpa_sts_t;

endpackage

[rtl/core/ftpa_if.sv]
// valid/ready channel interface
interface ftpa_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/ftpa_ram.sv]
// generic single-port ram with registered read
module ftpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/core/ftpa_datapath.sv]
// hash unit, probe index, slot clearing and record update
module ftpa_datapath #(
  parameter int TableSlots = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ftpa_pkg::pkt_hdr_t hdr_i,
  input  ftpa_pkg::ftpa_cmd_t cmd_i,
  output ftpa_pkg::ftpa_sts_t sts_o,
  output ftpa_pkg::flow_res_t res_o
);
  import ftpa_pkg::*;

  localparam int IdxW = $clog2(TableSlots);
  localparam int CntW = IdxW + 1;
  localparam logic [CntW+3:0] LoadLimit = (CntW+4)'((TableSlots * LoadNum) / LoadDen);

  pkt_hdr_t    hdr_q;
  logic        rev_q;
  logic [63:0] ah_q, al_q, bh_q, bl_q;
  logic [43:0] rest_q;
  logic [303:0] bytes_q;
  logic [5:0]  byte_cnt_q;
  logic [63:0] hash_q;
  logic [IdxW-1:0] idx_q, start_q;
  logic [IdxW-1:0] clr_idx_q;
  logic        clr_busy_q;
  logic [CntW-1:0] count_q;
  logic [63:0] mix_x, mix;
  slot_rec_t   rd_rec, wr_rec, ram_wdata;
  logic        we, ram_we;
  logic [IdxW-1:0] ram_addr;
  logic        rev;
  logic [15:0] pa, pb;
  logic [63:0] first_ns, mn;
  logic [8:0]  fd;
  logic        take_flags;

  always_comb begin
    if (hdr_i.src_addr_hi != hdr_i.dst_addr_hi) begin
      rev = hdr_i.src_addr_hi > hdr_i.dst_addr_hi;
    end else if (hdr_i.src_addr_lo != hdr_i.dst_addr_lo) begin
      rev = hdr_i.src_addr_lo > hdr_i.dst_addr_lo;
    end else begin
      rev = hdr_i.port_src > hdr_i.port_dst;
    end
    pa = rev ? hdr_i.port_dst : hdr_i.port_src;
    pb = rev ? hdr_i.port_src : hdr_i.port_dst;
  end

  // fnv prime is 2^40 + 0x1b3, built from shifts and adds
  assign mix_x = hash_q ^ {56'd0, bytes_q[303:296]};
  assign mix   = (mix_x << 40) + (mix_x << 8) + (mix_x << 7) + (mix_x << 5) +
                 (mix_x << 4) + (mix_x << 1) + mix_x;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hdr_q  <= hdr_i;
      rev_q  <= rev;
      ah_q   <= rev ? hdr_i.dst_addr_hi : hdr_i.src_addr_hi;
      al_q   <= rev ? hdr_i.dst_addr_lo : hdr_i.src_addr_lo;
      bh_q   <= rev ? hdr_i.src_addr_hi : hdr_i.dst_addr_hi;
      bl_q   <= rev ? hdr_i.src_addr_lo : hdr_i.dst_addr_lo;
      rest_q <= {hdr_i.ip_ver, hdr_i.protocol, pa, pb};
      bytes_q <= {4'd0, hdr_i.ip_ver, hdr_i.protocol, pa, pb,
                  rev ? hdr_i.dst_addr_hi : hdr_i.src_addr_hi,
                  rev ? hdr_i.dst_addr_lo : hdr_i.src_addr_lo,
                  rev ? hdr_i.src_addr_hi : hdr_i.dst_addr_hi,
                  rev ? hdr_i.src_addr_lo : hdr_i.dst_addr_lo};
      hash_q <= FnvBasis;
    end else if (cmd_i.hash_step) begin
      hash_q  <= mix;
      bytes_q <= {bytes_q[295:0], 8'd0};
    end
    if (cmd_i.probe_init) begin
      idx_q   <= hash_q[IdxW-1:0];
      start_q <= hash_q[IdxW-1:0];
    end else if (cmd_i.probe_next) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      count_q    <= '0;
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      if (cmd_i.load) begin
        byte_cnt_q <= '0;
      end else if (cmd_i.hash_step) begin
        byte_cnt_q <= byte_cnt_q + 6'd1;
      end
      if (cmd_i.wr_new) begin
        count_q <= count_q + CntW'(1);
      end
      // one slot marked empty per cycle after reset
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + IdxW'(1);
        if (clr_idx_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  assign take_flags = hdr_q.protocol == ProtoTcp && hdr_q.header_level != LvlL3;

  always_comb begin
    first_ns = cmd_i.wr_new ? hdr_q.timestamp_ns : rd_rec.first_ns;
    fd       = cmd_i.wr_new ? {rev_q, 8'd0} : rd_rec.flags_dir;
    mn       = first_ns;
    if (hdr_q.timestamp_ns < first_ns) begin
      mn = hdr_q.timestamp_ns;
      fd = {rev_q, fd[7:0]};
    end
    if (take_flags) begin
      fd[7:0] = fd[7:0] | hdr_q.tcp_flag_bits;
    end
    wr_rec.vld       = 1'b1;
    wr_rec.addr_a_hi = ah_q;
    wr_rec.addr_a_lo = al_q;
    wr_rec.addr_b_hi = bh_q;
    wr_rec.addr_b_lo = bl_q;
    wr_rec.key_rest  = rest_q;
    wr_rec.hash      = hash_q;
    wr_rec.packets   = (cmd_i.wr_new ? 64'd0 : rd_rec.packets) + 64'd1;
    wr_rec.bytes     = (cmd_i.wr_new ? 64'd0 : rd_rec.bytes) + {32'd0, hdr_q.wire_length};
    wr_rec.first_ns  = mn;
    wr_rec.last_ns   = (!cmd_i.wr_new && rd_rec.last_ns >= hdr_q.timestamp_ns)
                       ? rd_rec.last_ns : hdr_q.timestamp_ns;
    wr_rec.flags_dir = fd;
  end

  assign we        = cmd_i.wr_new | cmd_i.wr_upd;
  assign ram_we    = clr_busy_q | we;
  assign ram_addr  = clr_busy_q ? clr_idx_q : idx_q;
  assign ram_wdata = clr_busy_q ? slot_rec_t'('0) : wr_rec;

  ftpa_ram #(.Width($bits(slot_rec_t)), .Depth(TableSlots)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_rec)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      res_o <= flow_res_t'({(hdr_q.header_level == LvlNone) ? StIgnored : StFull,
                            {($bits(flow_res_t) - 2){1'b0}}});
    end else if (we) begin
      res_o.status          <= cmd_i.wr_new ? StNew : StUpdated;
      res_o.slot_index      <= 10'(idx_q);
      res_o.packet_reversed <= rev_q;
      res_o.flow_packets    <= wr_rec.packets;
      res_o.flow_bytes      <= wr_rec.bytes;
      res_o.flow_first_ns   <= wr_rec.first_ns;
      res_o.flow_last_ns    <= wr_rec.last_ns;
      res_o.flow_tcp_flags  <= wr_rec.flags_dir[7:0];
      res_o.first_dir_b     <= wr_rec.flags_dir[8];
    end
  end

  always_comb begin
    sts_o.clearing   = clr_busy_q;
    sts_o.no_l3      = hdr_q.header_level == LvlNone;
    sts_o.hash_done  = byte_cnt_q == 6'd38;
    sts_o.slot_valid = rd_rec.vld;
    sts_o.key_match  = rd_rec.hash == hash_q && rd_rec.key_rest == rest_q &&
                       rd_rec.addr_a_hi == ah_q && rd_rec.addr_a_lo == al_q &&
                       rd_rec.addr_b_hi == bh_q && rd_rec.addr_b_lo == bl_q;
    sts_o.wrapped    = (idx_q + IdxW'(1)) == start_q;
    sts_o.load_full  = ({4'd0, count_q} + (CntW+4)'(1)) > LoadLimit;
  end
endmodule

[rtl/core/ftpa_ctrl.sv]
// sequencer for hash, probe, write and result transfer
module ftpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ftpa_pkg::ftpa_sts_t sts_i,
  output ftpa_pkg::ftpa_cmd_t cmd_o
);
  import ftpa_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SCheck, SHash, SRead, SComp, SDone
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   done_pending;

  assign in_ready_o  = state_q == SIdle && !out_valid_q && !sts_i.clearing;
  assign out_valid_o = out_valid_q;
  assign done_pending = out_valid_q && !out_ready_i;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      SIdle:  cmd_o.load = in_valid_i && in_ready_o;
      SCheck: begin
        cmd_o.res_zero  = sts_i.no_l3;
        cmd_o.hash_step = !sts_i.no_l3;
      end
      SHash: begin
        cmd_o.hash_step  = !sts_i.hash_done;
        cmd_o.probe_init = sts_i.hash_done;
      end
      SComp: begin
        if (!sts_i.slot_valid) begin
          cmd_o.res_zero = sts_i.load_full;
          cmd_o.wr_new   = !sts_i.load_full;
        end else if (sts_i.key_match) begin
          cmd_o.wr_upd = 1'b1;
        end else if (sts_i.wrapped) begin
          cmd_o.res_zero = 1'b1;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      SRead, SDone: cmd_o = '0;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle:  if (cmd_o.load) begin
          state_q <= SCheck;
        end
        SCheck: begin
          if (sts_i.no_l3) begin
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end else begin
            state_q <= SHash;
          end
        end
        SHash:  if (sts_i.hash_done) begin
          state_q <= SRead;
        end
        SRead:  state_q <= SComp;
        SComp: begin
          if (cmd_o.probe_next) begin
            state_q <= SRead;
          end else begin
            out_valid_q <= 1'b1;
            state_q     <= SDone;
          end
        end
        SDone:  if (!done_pending) begin
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

[rtl/core/flow_table_packet_accumulate_unit.sv]
// flow table accumulator top level
//  channel  dir  payload
//  in_if    in   pkt_hdr_t, packet header record
//  out_if   out  flow_res_t, flow record after update
// an l3 item is hashed with fnv-1a at one byte per cycle over 38 key bytes, then takes one
// ram read and compare per probed slot before its result is shown; items with no l3 header
// skip the hash and the table. a new item is taken only after the last result is taken.
// after reset a clearing pass marks every slot empty, one per cycle, and holds off input;
// a stalled result holds off the next input.
module flow_table_packet_accumulate_unit #(
  parameter int TABLE_SLOTS = 1024
) (
  input logic clk_i,
  input logic rst_ni,
  ftpa_if.sink   in_if,
  ftpa_if.source out_if
);
  import ftpa_pkg::*;

  ftpa_cmd_t cmd;
  ftpa_sts_t sts;
  flow_res_t res;

  ftpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ftpa_datapath #(.TableSlots(TABLE_SLOTS)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hdr_i  (in_if.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign out_if.data = res;
endmodule

[rtl/core/ftpa_checker.sv]
// port-level checks bound to the top level
`include "assert_macros.svh"
module ftpa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] out_status_i
);
  `ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_no_quick_result, clk_i, rst_ni, in_valid_i && in_ready_i, !out_valid_i)
  `ASSERT_NEXT(a_status_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_status_i))
endmodule

bind flow_table_packet_accumulate_unit ftpa_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_status_i (out_if.data.status)
);
